### rtl/spk_pkg.sv
// speck48/96 package: word and stage types, round and key schedule functions
// used by speck48_96_cipher; no dependencies
package spk_pkg;

    localparam int WordW     = 24;
    localparam int NumRounds = 23;
    localparam int NumStages = 2 * NumRounds;
    localparam int IdxW      = $clog2(NumRounds);

    typedef logic [WordW-1:0] t_word;
    typedef logic [IdxW-1:0]  t_idx;

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    // one pipeline stage: block halves plus the running key schedule window
    typedef struct packed {
        t_mode mode;
        t_word k;
        t_word l0;
        t_word l1;
        t_word l2;
        t_word x;
        t_word y;
    } t_stage;

    function automatic t_word ror8(t_word v);
        return {v[7:0], v[WordW-1:8]};
    endfunction

    function automatic t_word rol8(t_word v);
        return {v[WordW-9:0], v[WordW-1:WordW-8]};
    endfunction

    function automatic t_word ror3(t_word v);
        return {v[2:0], v[WordW-1:3]};
    endfunction

    function automatic t_word rol3(t_word v);
        return {v[WordW-4:0], v[WordW-1:WordW-3]};
    endfunction

    // forward half: encrypt round (encrypt mode) with current key, then key schedule step idx
    function automatic t_stage fwd_stage(t_stage d, t_idx idx, logic last);
        t_stage q;
        t_word  rx;
        t_word  nl;
        q = d;
        if (d.mode == MODE_ENC) begin
            rx  = (ror8(d.x) + d.y) ^ d.k;
            q.x = rx;
            q.y = rol3(d.y) ^ rx;
        end
        if (!last) begin
            nl   = (ror8(d.l0) + d.k) ^ t_word'(idx);
            q.k  = rol3(d.k) ^ nl;
            q.l0 = d.l1;
            q.l1 = d.l2;
            q.l2 = nl;
        end
        return q;
    endfunction

    // backward half: decrypt round (decrypt mode) with current key, then undo key step idx
    function automatic t_stage bwd_stage(t_stage d, t_idx idx, logic last);
        t_stage q;
        t_word  ry;
        t_word  kp;
        q = d;
        if (d.mode == MODE_DEC) begin
            ry  = ror3(d.y ^ d.x);
            q.y = ry;
            q.x = rol8((d.x ^ d.k) - ry);
        end
        if (!last) begin
            kp   = ror3(d.k ^ d.l2);
            q.k  = kp;
            q.l2 = d.l1;
            q.l1 = d.l0;
            q.l0 = rol8((d.l2 ^ t_word'(idx)) - kp);
        end
        return q;
    endfunction

endpackage

### rtl/speck48_96_cipher.sv
// speck48/96 cipher core: 46-stage pipeline, key schedule runs forward then backward
// depends on spk_pkg
// throughput: one block per cycle unless the output stalls; stages 0-22 run encrypt
// rounds in encrypt mode with the forward key schedule, stages 23-45 run decrypt
// rounds in decrypt mode while undoing the schedule
// a stalled output only holds back stages that are full; bubbles still fill
// reset (synchronous, active low) clears all stage valid bits
module speck48_96_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [23:0] i_key_word0,
    input  logic [23:0] i_key_word1,
    input  logic [23:0] i_key_word2,
    input  logic [23:0] i_key_word3,
    input  logic [23:0] i_block_low,
    input  logic [23:0] i_block_high,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_low,
    output logic [23:0] o_out_high
);

    localparam int Last = spk_pkg::NumStages - 1;

    spk_pkg::t_stage                  r_stage [spk_pkg::NumStages];
    spk_pkg::t_stage                  n_stage [spk_pkg::NumStages];
    logic [spk_pkg::NumStages-1:0]    r_valid;
    logic [spk_pkg::NumStages-1:0]    w_en;
    logic [spk_pkg::NumStages-1:0]    w_vin;
    spk_pkg::t_stage                  w_in;

    always_comb begin
        w_in.mode = spk_pkg::t_mode'(i_mode);
        w_in.k    = i_key_word0;
        w_in.l0   = i_key_word1;
        w_in.l1   = i_key_word2;
        w_in.l2   = i_key_word3;
        w_in.x    = i_block_high;
        w_in.y    = i_block_low;
    end

    // a stage may load when it is empty or its content moves on
    assign w_en[Last] = !r_valid[Last] || i_out_ready;

    genvar s;
    generate
        for (s = 0; s < spk_pkg::NumStages; s++) begin : g_stage
            spk_pkg::t_stage w_d;

            if (s < Last) begin : g_en
                assign w_en[s] = !r_valid[s] || w_en[s+1];
            end

            if (s == 0) begin : g_first
                assign w_d      = w_in;
                assign w_vin[s] = i_in_valid;
            end else begin : g_mid
                assign w_d      = r_stage[s-1];
                assign w_vin[s] = r_valid[s-1];
            end

            if (s < spk_pkg::NumRounds) begin : g_fwd
                localparam logic IsLast = (s == spk_pkg::NumRounds - 1);
                assign n_stage[s] = spk_pkg::fwd_stage(w_d, spk_pkg::IdxW'(s), IsLast);
            end else begin : g_bwd
                localparam int   B      = s - spk_pkg::NumRounds;
                localparam logic IsLast = (B == spk_pkg::NumRounds - 1);
                localparam int   Idx    = IsLast ? 0 : spk_pkg::NumRounds - 2 - B;
                assign n_stage[s] = spk_pkg::bwd_stage(w_d, spk_pkg::IdxW'(Idx), IsLast);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (w_en[s]) begin
                    r_valid[s] <= w_vin[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[s] && w_vin[s]) begin
                    r_stage[s] <= n_stage[s];
                end
            end
        end
    endgenerate

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_valid[Last];
    assign o_out_low   = r_stage[Last].y;
    assign o_out_high  = r_stage[Last].x;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0))
        else $error("stage valid bits not cleared by reset");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted item did not enter first stage");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> o_in_ready)
        else $error("empty first stage refuses input");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[spk_pkg::NumRounds] && !w_en[spk_pkg::NumRounds])
            |=> (r_valid[spk_pkg::NumRounds] && $stable(r_stage[spk_pkg::NumRounds])))
        else $error("held stage lost or changed its item");

    a_bubble_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[0] && !r_valid[1]) |-> w_en[0])
        else $error("item stuck behind an empty stage");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// testbench for speck48_96_cipher: randomized encrypt/decrypt traffic with a
// scoreboard fed by a behavioral speck48/96 predictor; depends on spk_pkg
module tb;

    typedef struct packed {
        spk_pkg::t_mode mode;
        spk_pkg::t_word k0;
        spk_pkg::t_word k1;
        spk_pkg::t_word k2;
        spk_pkg::t_word k3;
        spk_pkg::t_word lo;
        spk_pkg::t_word hi;
    } t_blk_req;

    typedef struct packed {
        spk_pkg::t_word lo;
        spk_pkg::t_word hi;
    } t_blk_res;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    logic           out_ready = 1'b0;
    t_blk_req       drv_item  = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    spk_pkg::t_word o_out_low;
    spk_pkg::t_word o_out_high;

    t_blk_req req_q[$];
    t_blk_res cipher_q[$];
    int       sent_cnt = 0;
    int       rcvd_cnt = 0;
    int       fail_cnt = 0;
    logic     sender_calm;
    logic     receiver_calm;

    speck48_96_cipher uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (drv_item.mode),
        .i_key_word0  (drv_item.k0),
        .i_key_word1  (drv_item.k1),
        .i_key_word2  (drv_item.k2),
        .i_key_word3  (drv_item.k3),
        .i_block_low  (drv_item.lo),
        .i_block_high (drv_item.hi),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stretches where one side never idles
    assign sender_calm   = (sent_cnt >= 200) && (sent_cnt < 320);
    assign receiver_calm = (rcvd_cnt >= 250) && (rcvd_cnt < 400);

    function automatic spk_pkg::t_word rotr(spk_pkg::t_word v, int n);
        return (v >> n) | (v << (spk_pkg::WordW - n));
    endfunction

    function automatic spk_pkg::t_word rotl(spk_pkg::t_word v, int n);
        return (v << n) | (v >> (spk_pkg::WordW - n));
    endfunction

    function automatic t_blk_res speck_cipher(t_blk_req r);
        spk_pkg::t_word rk [spk_pkg::NumRounds];
        spk_pkg::t_word l0;
        spk_pkg::t_word l1;
        spk_pkg::t_word l2;
        spk_pkg::t_word nl;
        spk_pkg::t_word x;
        spk_pkg::t_word y;
        t_blk_res       res;
        rk[0] = r.k0;
        l0 = r.k1;
        l1 = r.k2;
        l2 = r.k3;
        for (int i = 0; i < spk_pkg::NumRounds - 1; i++) begin
            nl = (rotr(l0, 8) + rk[i]) ^ spk_pkg::t_word'(i);
            rk[i+1] = rotl(rk[i], 3) ^ nl;
            l0 = l1;
            l1 = l2;
            l2 = nl;
        end
        x = r.hi;
        y = r.lo;
        for (int i = 0; i < spk_pkg::NumRounds; i++) begin
            if (r.mode == spk_pkg::MODE_ENC) begin
                x = (rotr(x, 8) + y) ^ rk[i];
                y = rotl(y, 3) ^ x;
            end else begin
                y = rotr(y ^ x, 3);
                x = rotl((x ^ rk[spk_pkg::NumRounds-1-i]) - y, 8);
            end
        end
        res.lo = y;
        res.hi = x;
        return res;
    endfunction

    task automatic queue_req(spk_pkg::t_mode m, spk_pkg::t_word k0, spk_pkg::t_word k1,
                             spk_pkg::t_word k2, spk_pkg::t_word k3,
                             spk_pkg::t_word lo, spk_pkg::t_word hi);
        t_blk_req r;
        r = '{mode: m, k0: k0, k1: k1, k2: k2, k3: k3, lo: lo, hi: hi};
        req_q.push_back(r);
    endtask

    function automatic spk_pkg::t_word rand_word();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return spk_pkg::t_word'($urandom);
    endfunction

    // random blocks; some encrypts are followed by a decrypt of their ciphertext
    task automatic queue_random(int n);
        t_blk_req r;
        t_blk_res c;
        int       cnt;
        cnt = 0;
        while (cnt < n) begin
            r.mode = spk_pkg::t_mode'($urandom_range(1));
            r.k0 = rand_word();
            r.k1 = rand_word();
            r.k2 = rand_word();
            r.k3 = rand_word();
            r.lo = rand_word();
            r.hi = rand_word();
            req_q.push_back(r);
            cnt++;
            if (r.mode == spk_pkg::MODE_ENC && $urandom_range(3) == 0) begin
                c = speck_cipher(r);
                r.mode = spk_pkg::MODE_DEC;
                r.lo = c.lo;
                r.hi = c.hi;
                req_q.push_back(r);
                cnt++;
            end
        end
    endtask

    task automatic drain();
        while (req_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) begin
                cipher_q.push_back(speck_cipher(drv_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (req_q.size() != 0 && (sender_calm || $urandom_range(99) >= 9)) begin
                drv_item <= req_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= receiver_calm || ($urandom_range(99) >= 9);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_blk_res want;
        if (i_rst_n && o_out_valid && out_ready) begin
            rcvd_cnt <= rcvd_cnt + 1;
            if (cipher_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: lo %h hi %h", o_out_low, o_out_high);
            end else begin
                want = cipher_q.pop_front();
                if (o_out_low !== want.lo || o_out_high !== want.hi) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch: expected lo %h hi %h, got lo %h hi %h",
                                 want.lo, want.hi, o_out_low, o_out_high);
                end
            end
        end
    end

    initial begin
        // all-zero, all-one and single-bit patterns in both modes
        queue_req(spk_pkg::MODE_ENC, '0, '0, '0, '0, '0, '0);
        queue_req(spk_pkg::MODE_DEC, '0, '0, '0, '0, '0, '0);
        queue_req(spk_pkg::MODE_ENC, '1, '1, '1, '1, '1, '1);
        queue_req(spk_pkg::MODE_DEC, '1, '1, '1, '1, '1, '1);
        // published test vector and its inverse
        queue_req(spk_pkg::MODE_ENC, 24'h020100, 24'h0a0908, 24'h121110, 24'h1a1918,
                  24'h696874, 24'h6d2073);
        queue_req(spk_pkg::MODE_DEC, 24'h020100, 24'h0a0908, 24'h121110, 24'h1a1918,
                  24'hb6445d, 24'h735e10);
        queue_req(spk_pkg::MODE_ENC, '1, '1, '1, '1, '0, '0);
        queue_req(spk_pkg::MODE_DEC, '1, '1, '1, '1, '0, '0);
        queue_req(spk_pkg::MODE_ENC, '0, '0, '0, '0, '1, '1);
        queue_req(spk_pkg::MODE_DEC, '0, '0, '0, '0, '1, '1);
        queue_req(spk_pkg::MODE_ENC, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h800000);
        queue_req(spk_pkg::MODE_DEC, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h800000);
        queue_req(spk_pkg::MODE_ENC, 24'h000001, 24'h000001, 24'h000001, 24'h000001,
                  24'h000001, 24'h000001);
        queue_req(spk_pkg::MODE_DEC, 24'h000001, 24'h000001, 24'h000001, 24'h000001,
                  24'h000001, 24'h000001);
        queue_req(spk_pkg::MODE_ENC, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555,
                  24'haaaaaa, 24'h555555);
        queue_req(spk_pkg::MODE_DEC, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
                  24'h555555, 24'haaaaaa);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();
        queue_random(350);
        // sender holds off until the pipeline has emptied
        drain();
        queue_random(350);
        drain();
        repeat (60) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### files.f
rtl/spk_pkg.sv
rtl/speck48_96_cipher.sv
verif/tb.sv
